// ----- hw/rtl/cvp_pkg.sv -----
// Shared types and constants for the camera view projection block.
`default_nettype none
package cvp_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned PosW = 32;
  // A position difference spans 33 bits; rotation stages grow by up to two bits.
  localparam int unsigned DiffW = PosW + 1;
  localparam int unsigned Rot1W = DiffW + 2;
  localparam int unsigned Rot2W = Rot1W + 2;
  localparam int unsigned Rot3W = Rot2W + 2;
  // Numerator: rotated value times focal (13 bit signed) plus center times depth.
  localparam int unsigned NumW = Rot3W + 18;
  localparam int unsigned QuotW = NumW;

  localparam logic [2:0] RegCamX = 3'd0;
  localparam logic [2:0] RegCamY = 3'd1;
  localparam logic [2:0] RegCamZ = 3'd2;
  localparam logic [2:0] RegRotZ = 3'd3;
  localparam logic [2:0] RegRotY = 3'd4;
  localparam logic [2:0] RegRotX = 3'd5;
  localparam logic [2:0] RegFocal = 3'd6;
  localparam logic [2:0] RegCenter = 3'd7;

  localparam int unsigned CfgIdxW = 4;

  // Divider control carried alongside each lane's quotient bits.
  typedef struct packed {
    logic valid;
    logic zero;
  } div_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/cvp_divider.sv -----
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
`default_nettype none
module cvp_divider (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  input  wire cvp_pkg::div_ctl_t               ctl_i,
  input  wire logic signed [cvp_pkg::NumW-1:0]  num_i,
  input  wire logic signed [cvp_pkg::Rot3W-1:0] den_i,
  output cvp_pkg::div_ctl_t                     ctl_o,
  output logic signed [15:0]                    quot_o
);

  localparam int unsigned NW = cvp_pkg::NumW;
  localparam int unsigned DW = cvp_pkg::Rot3W;
  localparam int unsigned Steps = NW;

  // Per-stage magnitude state: remainder, dividend shift register, sign.
  logic [DW-1:0]       rem_q [Steps+1];
  logic [NW-1:0]       dvd_q [Steps+1];
  logic [DW-1:0]       dsr_q [Steps+1];
  logic                neg_q [Steps+1];
  cvp_pkg::div_ctl_t   ctl_q [Steps+1];

  logic [NW-1:0] num_abs;
  logic [DW-1:0] den_abs;
  assign num_abs = num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
  assign den_abs = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);

  // Entry stage takes magnitudes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q[0] <= '0;
    end else begin
      ctl_q[0] <= ctl_i;
    end
  end
  always_ff @(posedge clk_i) begin
    rem_q[0] <= '0;
    dvd_q[0] <= num_abs;
    dsr_q[0] <= den_abs;
    neg_q[0] <= num_i[NW-1] ^ den_i[DW-1];
  end

  // Restoring division: each stage settles one quotient bit into the dividend LSB.
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [DW:0]   trial;
    logic [DW:0]   shifted;
    assign shifted = {rem_q[s], dvd_q[s][NW-1]};
    assign trial = shifted - {1'b0, dsr_q[s]};
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        ctl_q[s+1] <= '0;
      end else begin
        ctl_q[s+1] <= ctl_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rem_q[s+1] <= trial[DW] ? shifted[DW-1:0] : trial[DW-1:0];
      dvd_q[s+1] <= {dvd_q[s][NW-2:0], ~trial[DW]};
      dsr_q[s+1] <= dsr_q[s];
      neg_q[s+1] <= neg_q[s];
    end
  end

  // Sign restore and saturation to 16 bits.
  logic signed [NW:0] q_signed;
  always_comb begin
    q_signed = neg_q[Steps] ? -$signed({1'b0, dvd_q[Steps]}) : $signed({1'b0, dvd_q[Steps]});
    if (ctl_q[Steps].zero) begin
      quot_o = '0;
    end else if (q_signed > (NW+1)'(32767)) begin
      quot_o = 16'sh7fff;
    end else if (q_signed < -(NW+1)'(32768)) begin
      quot_o = -16'sh8000;
    end else begin
      quot_o = q_signed[15:0];
    end
  end
  assign ctl_o = ctl_q[Steps];

endmodule
`default_nettype wire

// ----- hw/rtl/camera_view_projection.sv -----
// Top level of the camera view projection pipeline.
// Usage: pulse start with point_x_i/point_y_i/point_z_i; busy is always low,
// so one point transaction is accepted every cycle. Configuration registers are
// written over cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; the user
// must write them only while no point is in flight; the block does not enforce it.
// Register indexes beyond the list are ignored. Each point yields one result:
// done_o is high for one cycle with screen_x_o, screen_y_o and depth_zero_o. The
// result passes one register for the camera offset, two per rotation axis
// (multiply, then sum and floor shift), one for the focal and center products, one
// for the numerator sum, one for the divider entry and one per quotient bit in the
// pipelined restoring divider, which holds most of the stages.
// Throughput is one point per cycle.
// The receiver cannot stall: results appear once and must be taken.
// Reset returns the registers to identity rotation, zero camera position,
// focal scale 640 and center (320, 240), and empties the pipeline.
`default_nettype none
module camera_view_projection (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  wire signed [31:0] point_x_i,
  input  wire signed [31:0] point_y_i,
  input  wire signed [31:0] point_z_i,
  output logic              done_o,
  output logic signed [15:0] screen_x_o,
  output logic signed [15:0] screen_y_o,
  output logic              depth_zero_o,
  input  wire               cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire [cvp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire [31:0]        cfg_data_i
);

  localparam int unsigned DW = cvp_pkg::DiffW;
  localparam int unsigned R1 = cvp_pkg::Rot1W;
  localparam int unsigned R2 = cvp_pkg::Rot2W;
  localparam int unsigned R3 = cvp_pkg::Rot3W;
  localparam int unsigned NW = cvp_pkg::NumW;

  assign busy = 1'b0;
  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  logic [31:0] cam_x_q, cam_y_q, cam_z_q, rz_q, ry_q, rx_q, ctr_q;
  logic [11:0] foc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q <= '0; cam_y_q <= '0; cam_z_q <= '0;
      rz_q <= 32'd16384; ry_q <= 32'd16384; rx_q <= 32'd16384;
      foc_q <= 12'd640; ctr_q <= 32'h00F00140;
    end else if (cfg_valid_i && cfg_index_i[3] == 1'b0) begin
      case (cfg_index_i[2:0])
        cvp_pkg::RegCamX:   cam_x_q <= cfg_data_i;
        cvp_pkg::RegCamY:   cam_y_q <= cfg_data_i;
        cvp_pkg::RegCamZ:   cam_z_q <= cfg_data_i;
        cvp_pkg::RegRotZ:   rz_q <= cfg_data_i;
        cvp_pkg::RegRotY:   ry_q <= cfg_data_i;
        cvp_pkg::RegRotX:   rx_q <= cfg_data_i;
        cvp_pkg::RegFocal:  foc_q <= cfg_data_i[11:0];
        cvp_pkg::RegCenter: ctr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic signed [15:0] sz, cz, sy, cy, sx, cx;
  assign sz = rz_q[31:16]; assign cz = rz_q[15:0];
  assign sy = ry_q[31:16]; assign cy = ry_q[15:0];
  assign sx = rx_q[31:16]; assign cx = rx_q[15:0];

  // Valid bits through the arithmetic stages.
  logic [8:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else v_q <= {v_q[7:0], start};
  end

  // Stage 0: camera offset.
  logic signed [DW-1:0] dx_q, dy_q, dz_q;
  always_ff @(posedge clk_i) begin
    dx_q <= DW'(point_x_i) - DW'($signed(cam_x_q));
    dy_q <= DW'(point_y_i) - DW'($signed(cam_y_q));
    dz_q <= DW'(point_z_i) - DW'($signed(cam_z_q));
  end

  // Stage 1-2: rotation about Z.
  logic signed [DW+15:0] pa_q, pb_q, pc_q, pd_q;
  logic signed [DW-1:0]  z1a_q, z1_q;
  always_ff @(posedge clk_i) begin
    pa_q <= dx_q * cz; pb_q <= dy_q * sz;
    pc_q <= dx_q * sz; pd_q <= dy_q * cz;
    z1a_q <= dz_q;
  end
  logic signed [R1-1:0] x1_q, y1_q;
  logic signed [DW+16:0] s_x1, s_y1;
  assign s_x1 = (DW+17)'(pa_q) - (DW+17)'(pb_q);
  assign s_y1 = (DW+17)'(pc_q) + (DW+17)'(pd_q);
  always_ff @(posedge clk_i) begin
    x1_q <= R1'(s_x1 >>> 14);
    y1_q <= R1'(s_y1 >>> 14);
    z1_q <= z1a_q;
  end

  // Stage 3-4: rotation about Y.
  logic signed [R1+15:0] qa_q, qb_q, qc_q, qd_q;
  logic signed [R1-1:0]  y1a_q, y1b_q;
  always_ff @(posedge clk_i) begin
    qa_q <= x1_q * cy; qb_q <= R1'(z1_q) * sy;
    qc_q <= R1'(z1_q) * cy; qd_q <= x1_q * sy;
    y1a_q <= y1_q;
  end
  logic signed [R2-1:0] x2_q, z2_q;
  logic signed [R1+16:0] s_x2, s_z2;
  assign s_x2 = (R1+17)'(qa_q) + (R1+17)'(qb_q);
  assign s_z2 = (R1+17)'(qc_q) - (R1+17)'(qd_q);
  always_ff @(posedge clk_i) begin
    x2_q <= R2'(s_x2 >>> 14);
    z2_q <= R2'(s_z2 >>> 14);
    y1b_q <= y1a_q;
  end

  // Stage 5-6: rotation about X.
  logic signed [R2+15:0] ra_q, rb_q, rc_q, rd_q;
  logic signed [R2-1:0]  x2a_q, x2b_q;
  always_ff @(posedge clk_i) begin
    ra_q <= R2'(y1b_q) * cx; rb_q <= z2_q * sx;
    rc_q <= R2'(y1b_q) * sx; rd_q <= z2_q * cx;
    x2a_q <= x2_q;
  end
  logic signed [R3-1:0] y3_q, z3_q;
  logic signed [R2+16:0] s_y3, s_z3;
  assign s_y3 = (R2+17)'(ra_q) - (R2+17)'(rb_q);
  assign s_z3 = (R2+17)'(rc_q) + (R2+17)'(rd_q);
  always_ff @(posedge clk_i) begin
    y3_q <= R3'(s_y3 >>> 14);
    z3_q <= R3'(s_z3 >>> 14);
    x2b_q <= x2a_q;
  end

  // Stage 7: focal and center products.
  logic signed [NW-1:0] fx_q, fy_q, cxz_q, cyz_q;
  logic signed [R3-1:0] z3a_q;
  logic signed [12:0] foc_s;
  assign foc_s = $signed({1'b0, foc_q});
  always_ff @(posedge clk_i) begin
    fx_q <= NW'(R3'(x2b_q) * foc_s);
    fy_q <= NW'(y3_q * foc_s);
    cxz_q <= NW'(z3_q * $signed(ctr_q[15:0]));
    cyz_q <= NW'(z3_q * $signed(ctr_q[31:16]));
    z3a_q <= z3_q;
  end

  // Stage 8: numerators.
  logic signed [NW-1:0] nx_q, ny_q;
  logic signed [R3-1:0] den_q;
  always_ff @(posedge clk_i) begin
    nx_q <= fx_q + cxz_q;
    ny_q <= fy_q + cyz_q;
    den_q <= z3a_q;
  end

  cvp_pkg::div_ctl_t ctl_in, ctl_x, ctl_y;
  assign ctl_in.valid = v_q[8];
  assign ctl_in.zero = (den_q == '0);

  cvp_divider u_div_x (
    .clk_i, .rst_ni, .ctl_i(ctl_in), .num_i(nx_q), .den_i(den_q),
    .ctl_o(ctl_x), .quot_o(screen_x_o)
  );
  cvp_divider u_div_y (
    .clk_i, .rst_ni, .ctl_i(ctl_in), .num_i(ny_q), .den_i(den_q),
    .ctl_o(ctl_y), .quot_o(screen_y_o)
  );

  assign done_o = ctl_x.valid;
  assign depth_zero_o = ctl_x.zero;

`ifndef SYNTH
  // Both divider lanes stay in lockstep.
  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni) ctl_x == ctl_y)
    else $error("divider lanes out of step");
  // A zero-depth result projects to the origin.
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && depth_zero_o |-> screen_x_o == 0 && screen_y_o == 0)
    else $error("zero depth gave nonzero coordinates");
  // Accepted items enter the valid line in the next cycle.
  a_enter: assert property (@(posedge clk_i) disable iff (!rst_ni) start |=> v_q[0])
    else $error("accepted item lost");
`endif

endmodule
`default_nettype wire

// ----- bench/camera_view_projection_tb.sv -----
// Self-checking testbench for the camera view projection block.
`timescale 1ns / 1ps
module camera_view_projection_tb;

  // Index that lies outside the register list; the block must ignore it.
  localparam logic [cvp_pkg::CfgIdxW-1:0] RegNone = cvp_pkg::CfgIdxW'(9);
  localparam int unsigned SettleCycles = 100;
  localparam int unsigned PhasePoints = 275;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               zero;
  } screen_t;

  typedef enum logic {ROW_POINT, ROW_REG} row_kind_e;

  typedef struct {
    row_kind_e                   kind;
    logic [cvp_pkg::CfgIdxW-1:0] idx;
    logic [31:0]                 a, b, c;
    bit                          typed;
    screen_t                     want;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] point_x_i = '0, point_y_i = '0, point_z_i = '0;
  logic done_o;
  logic signed [15:0] screen_x_o, screen_y_o;
  logic depth_zero_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [cvp_pkg::CfgIdxW-1:0] cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  // Shadow copy of the configuration registers.
  logic signed [31:0] cam_x, cam_y, cam_z;
  logic [31:0] rot_z, rot_y, rot_x, center;
  logic [11:0] focal;

  screen_t pending_screen[$];
  int unsigned errors = 0;
  int unsigned points_sent = 0;
  int unsigned results_seen = 0;
  int unsigned zero_depths = 0;
  int unsigned idle_pct = 0;

  camera_view_projection i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .point_x_i, .point_y_i, .point_z_i,
    .done_o, .screen_x_o, .screen_y_o, .depth_zero_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  function automatic logic signed [15:0] clamp16(input longint v);
    if (v < -32768) return -16'sd32768;
    if (v > 32767) return 16'sd32767;
    return v[15:0];
  endfunction

  // Camera offset, three rotations with floor shifts, then exact projection.
  function automatic screen_t project_point(input logic signed [31:0] px, py, pz);
    longint dx, dy, dz, sz, cz, sy, cy, sx, cx;
    longint x1, y1, x2, z2, y3, z3, nx, ny;
    screen_t r;
    dx = longint'(px) - longint'(cam_x);
    dy = longint'(py) - longint'(cam_y);
    dz = longint'(pz) - longint'(cam_z);
    sz = longint'($signed(rot_z[31:16]));
    cz = longint'($signed(rot_z[15:0]));
    sy = longint'($signed(rot_y[31:16]));
    cy = longint'($signed(rot_y[15:0]));
    sx = longint'($signed(rot_x[31:16]));
    cx = longint'($signed(rot_x[15:0]));
    x1 = (dx * cz - dy * sz) >>> 14;
    y1 = (dx * sz + dy * cz) >>> 14;
    x2 = (x1 * cy + dz * sy) >>> 14;
    z2 = (dz * cy - x1 * sy) >>> 14;
    y3 = (y1 * cx - z2 * sx) >>> 14;
    z3 = (y1 * sx + z2 * cx) >>> 14;
    r = '0;
    if (z3 == 0) begin
      r.zero = 1'b1;
    end else begin
      nx = x2 * longint'(focal) + longint'($signed(center[15:0])) * z3;
      ny = y3 * longint'(focal) + longint'($signed(center[31:16])) * z3;
      r.x = clamp16(nx / z3);
      r.y = clamp16(ny / z3);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  // Compare each result transaction against the oldest expectation.
  always @(posedge clk_i) begin
    screen_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_screen.size() == 0) begin
        $display("%0t: result transaction with nothing expected", $realtime);
        errors++;
      end else begin
        want = pending_screen.pop_front();
        if (screen_x_o !== want.x) report_mismatch("screen_x", screen_x_o, want.x);
        if (screen_y_o !== want.y) report_mismatch("screen_y", screen_y_o, want.y);
        if (depth_zero_o !== want.zero) report_mismatch("depth_zero", depth_zero_o, want.zero);
        if (want.zero) zero_depths++;
      end
    end
  end

  // Send one point, with an optional random gap before it.
  task automatic send_point(input logic [31:0] x, y, z, input bit typed, input screen_t want);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    point_x_i <= x;
    point_y_i <= y;
    point_z_i <= z;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    pending_screen.push_back(typed ? want : project_point(x, y, z));
    points_sent++;
  endtask

  // Registers change only once the pipeline has drained.
  task automatic write_reg(input logic [cvp_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
    start <= 1'b0;
    while (pending_screen.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      cvp_pkg::RegCamX: cam_x = data;
      cvp_pkg::RegCamY: cam_y = data;
      cvp_pkg::RegCamZ: cam_z = data;
      cvp_pkg::RegRotZ: rot_z = data;
      cvp_pkg::RegRotY: rot_y = data;
      cvp_pkg::RegRotX: rot_x = data;
      cvp_pkg::RegFocal: focal = data[11:0];
      cvp_pkg::RegCenter: center = data;
      default: ;
    endcase
  endtask

  function automatic row_t pt(input logic [31:0] x, y, z);
    row_t r;
    r = '{kind: ROW_POINT, idx: '0, a: x, b: y, c: z, typed: 1'b0, want: '0};
    return r;
  endfunction

  function automatic row_t pt_known(input logic [31:0] x, y, z,
                                    input logic signed [15:0] sx, sy, input logic zf);
    row_t r;
    r = pt(x, y, z);
    r.typed = 1'b1;
    r.want = '{x: sx, y: sy, zero: zf};
    return r;
  endfunction

  function automatic row_t reg_row(input logic [cvp_pkg::CfgIdxW-1:0] idx,
                                   input logic [31:0] data);
    row_t r;
    r = '{kind: ROW_REG, idx: idx, a: data, b: '0, c: '0, typed: 1'b0, want: '0};
    return r;
  endfunction

  // Sine and cosine of a random angle in Q1.14, or raw bits now and then.
  function automatic logic [31:0] random_rotation();
    real ang;
    logic signed [15:0] s, c;
    if ($urandom_range(7) == 0) return $urandom;
    ang = $urandom_range(0, 62831) / 10000.0;
    s = 16'(int'($sin(ang) * 16384.0));
    c = 16'(int'($cos(ang) * 16384.0));
    return {s, c};
  endfunction

  // Mostly points near the camera; some fully random, some exactly at it.
  function automatic logic [31:0] near(input logic [31:0] base, input int unsigned pick);
    if (pick < 2) return $urandom;
    if (pick == 2) return base;
    return base + 32'($signed($urandom_range(0, 32'h3F_FFFF)) - 32'sh20_0000);
  endfunction

  initial begin
    row_t plan[$];
    int unsigned pick;
    cam_x = '0; cam_y = '0; cam_z = '0;
    rot_z = 32'd16384; rot_y = 32'd16384; rot_x = 32'd16384;
    focal = 12'd640;
    center = 32'h00F0_0140;

    // Directed rows: reset state, extremes, saturation, zero and negative depth.
    plan.push_back(pt_known(32'h0, 32'h0, 32'h1_0000, 16'sd320, 16'sd240, 1'b0));
    plan.push_back(pt_known(32'h0, 32'h0, 32'h0, 16'sd0, 16'sd0, 1'b1));
    plan.push_back(pt_known(32'h1_0000, 32'h0, 32'h1_0000, 16'sd960, 16'sd240, 1'b0));
    plan.push_back(pt_known(32'h64_0000, 32'h0, 32'h1_0000, 16'sd32767, 16'sd240, 1'b0));
    plan.push_back(pt_known(-32'sh64_0000, 32'h0, 32'h1_0000, -16'sd32768, 16'sd240, 1'b0));
    plan.push_back(pt_known(32'h0, 32'h0, -32'sh1_0000, 16'sd320, 16'sd240, 1'b0));
    plan.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(pt(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    plan.push_back(reg_row(cvp_pkg::RegCamX, 32'h8000_0000));
    plan.push_back(reg_row(cvp_pkg::RegCamY, 32'h7FFF_FFFF));
    plan.push_back(reg_row(cvp_pkg::RegCamZ, 32'h8000_0000));
    plan.push_back(pt(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    plan.push_back(reg_row(cvp_pkg::RegRotZ, 32'h7FFF_8000));
    plan.push_back(reg_row(cvp_pkg::RegRotY, 32'h8000_7FFF));
    plan.push_back(reg_row(cvp_pkg::RegRotX, 32'h2D41_2D41));
    plan.push_back(reg_row(cvp_pkg::RegFocal, 32'hFFF));
    plan.push_back(reg_row(cvp_pkg::RegCenter, 32'h8000_7FFF));
    plan.push_back(pt(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F));
    plan.push_back(pt(32'hFFFF_FFFF, 32'h0, 32'h5555_AAAA));
    plan.push_back(reg_row(cvp_pkg::RegFocal, 32'h0));
    plan.push_back(pt(32'hA5A5_5A5A, 32'h0000_FFFF, 32'hFFFF_0000));
    plan.push_back(reg_row(RegNone, 32'hDEAD_BEEF));
    plan.push_back(pt(32'h3C3C_C3C3, 32'h7777_8888, 32'h0001_0000));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) write_reg(plan[i].idx, plan[i].a);
      else send_point(plan[i].a, plan[i].b, plan[i].c, plan[i].typed, plan[i].want);
    end

    // Random phases: new register settings each time; idling is light, then heavy, then off.
    for (int ph = 0; ph < 6; ph++) begin
      idle_pct = (ph < 2) ? 7 : (ph < 4) ? 64 : 0;
      write_reg(cvp_pkg::RegCamX,
                (ph == 0) ? 32'h7FFF_FFFF : (ph == 1) ? 32'h8000_0000 : $urandom);
      write_reg(cvp_pkg::RegCamY,
                (ph == 0) ? 32'h7FFF_FFFF : (ph == 1) ? 32'h8000_0000 : $urandom);
      write_reg(cvp_pkg::RegCamZ,
                (ph == 0) ? 32'h7FFF_FFFF : (ph == 1) ? 32'h8000_0000 : $urandom);
      write_reg(cvp_pkg::RegRotZ, (ph == 0) ? 32'h7FFF_7FFF : random_rotation());
      write_reg(cvp_pkg::RegRotY, (ph == 1) ? 32'h8000_8000 : random_rotation());
      write_reg(cvp_pkg::RegRotX, random_rotation());
      write_reg(cvp_pkg::RegFocal,
                (ph == 0) ? 32'hFFF : (ph == 1) ? 32'h1 : $urandom_range(1, 4095));
      write_reg(cvp_pkg::RegCenter,
                (ph < 2) ? {16'($urandom), 16'($urandom)} : $urandom);
      for (int n = 0; n < PhasePoints; n++) begin
        pick = $urandom_range(0, 19);
        if (pick == 2) send_point(cam_x, cam_y, cam_z, 1'b0, '0);
        else send_point(near(cam_x, pick), near(cam_y, pick), near(cam_z, pick), 1'b0, '0);
      end
    end

    start <= 1'b0;
    while (pending_screen.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d points over six register settings and three idling modes;", points_sent);
    $display("checked %0d results, %0d of them at zero depth.", results_seen, zero_depths);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still pending", pending_screen.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
